// File: hdl/dflc_pkg.sv
// ----------------------------------------------------------------------------
// Dusk fade light controller package
// Shared types, register indexes, reset values and state codes.
// ----------------------------------------------------------------------------
package dflc_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 16;
    localparam int THR_BITS    = 10;
    localparam int TICK_BITS   = 16;
    localparam int DUTY_BITS   = 7;
    localparam int STATE_BITS  = 2;
    localparam int ELAPSED_BITS = 16;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Divider: 100 * 65535 fits in 23 bits, one quotient bit per cycle.
    localparam int DIV_BITS     = 23;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DARK_THR  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LIGHT_THR = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FADE_TICKS = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_DUTY  = 2'd3;

    // Register reset values
    localparam logic [THR_BITS-1:0]  DARK_THR_RST   = 10'h090;
    localparam logic [THR_BITS-1:0]  LIGHT_THR_RST  = 10'h0a0;
    localparam logic [TICK_BITS-1:0] FADE_TICKS_RST = 16'd450;
    localparam logic [DUTY_BITS-1:0] MIN_DUTY_RST   = 7'd2;

    // Duty at full brightness
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = 7'd100;

    // Light state codes
    localparam logic [STATE_BITS-1:0] ST_LIGHT  = 2'd0;
    localparam logic [STATE_BITS-1:0] ST_DARK   = 2'd1;
    localparam logic [STATE_BITS-1:0] ST_FADING = 2'd2;

    // Input request payload
    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_req;

    // Result payload
    typedef struct packed {
        logic [STATE_BITS-1:0]   light_state;
        logic [DUTY_BITS-1:0]    duty_percent;
        logic                    leds_on;
        logic                    pwm_active;
        logic [ELAPSED_BITS-1:0] elapsed;
    } t_out_res;

endpackage

// File: hdl/dusk_fade_light_controller.sv
// A request's result is registered into the output register at commit, after the divider has
// run for a fading tick with a nonzero fade length: a bit-serial restoring divider forms
// 100*elapsed/fade_ticks one quotient bit per cycle over 23 dividend bits.
// One request is worked at a time; the next is taken as soon as the previous
// result is in the output register; a result commits only while that register is empty or read.
// Synchronous active-low reset returns the light state, idle count and register defaults.
// ----------------------------------------------------------------------------
// Dusk fade light controller
// Tracks light, fading and dark states from sensor samples and timer ticks,
// and works out the LED duty, steady level and PWM flag for each request.
// ----------------------------------------------------------------------------
module dusk_fade_light_controller #(
    parameter int COUNT_BITS = dflc_pkg::COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [dflc_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [dflc_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dflc_pkg::t_in_req                   i_in_data,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dflc_pkg::t_out_res                  o_out_data
);
    import dflc_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;
    localparam int SMP_CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam logic [COUNT_BITS-1:0] IDLE_MARK = {COUNT_BITS{1'b1}};

    // Sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Configuration registers
    logic [THR_BITS-1:0]  r_dark_thr;
    logic [THR_BITS-1:0]  r_light_thr;
    logic [TICK_BITS-1:0] r_fade_ticks;
    logic [DUTY_BITS-1:0] r_min_duty;

    // Controller state
    logic [1:0]            r_fsm, n_fsm;
    logic [STATE_BITS-1:0] r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [DUTY_BITS-1:0]  r_duty, n_duty;
    logic                  r_pwm, n_pwm;
    logic                  r_led, n_led;
    logic                  r_out_valid, n_out_valid;
    t_out_res              r_out, n_out;

    // Pending request results and divider
    logic                    r_apply, n_apply;
    logic [STATE_BITS-1:0]   r_p_state, n_p_state;
    logic [COUNT_BITS-1:0]   r_p_count, n_p_count;
    logic [DUTY_BITS-1:0]    r_pct, n_pct;
    logic [DIV_BITS-1:0]     r_dvd, n_dvd;
    logic [TICK_BITS-1:0]    r_rem, n_rem;
    logic [DUTY_BITS-1:0]    r_quo, n_quo;
    logic [DIV_CNT_BITS-1:0] r_dcnt, n_dcnt;

    logic                    accept;
    logic                    smp_dark;
    logic                    smp_light;
    logic                    fits;
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [TICK_BITS-1:0]    fc16;
    logic [DIV_BITS-1:0]     fc_ext;
    logic [TICK_BITS:0]      trial;
    logic                    trial_ge;
    logic [DUTY_BITS-1:0]    quo_next;
    logic [DUTY_BITS-1:0]    duty_fin;
    logic                    commit;

    assign accept   = (r_fsm == S_IDLE) && i_in_valid;
    assign smp_dark = SMP_CMP_BITS'(i_in_data.sample) < SMP_CMP_BITS'(r_dark_thr);
    assign smp_light = SMP_CMP_BITS'(i_in_data.sample) > SMP_CMP_BITS'(r_light_thr);
    assign fits     = CMP_BITS'(r_count) <= CMP_BITS'(r_fade_ticks);
    assign cnt_inc  = (r_count == IDLE_MARK) ? r_count : r_count + 1'b1;

    // The elapsed count is at most fade_ticks here, so 16 bits hold it.
    assign fc16   = TICK_BITS'(r_count);
    assign fc_ext = DIV_BITS'(fc16);

    // One restoring division step: bring in the next dividend bit.
    assign trial    = {r_rem, r_dvd[DIV_BITS-1]};
    assign trial_ge = trial >= {1'b0, r_fade_ticks};
    assign quo_next = {r_quo[DUTY_BITS-2:0], trial_ge};

    // Minimum duty clamp on the pending duty.
    assign duty_fin = (r_pct < r_min_duty) ? '0 : r_pct;
    assign commit   = (r_fsm == S_DONE) && (!r_out_valid || i_out_ready);

    // Next-state logic for the sequencer, the divider and the committed state.
    always_comb begin
        n_fsm       = r_fsm;
        n_state     = r_state;
        n_count     = r_count;
        n_duty      = r_duty;
        n_pwm       = r_pwm;
        n_led       = r_led;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_apply     = r_apply;
        n_p_state   = r_p_state;
        n_p_count   = r_p_count;
        n_pct       = r_pct;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dcnt      = r_dcnt;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    n_apply   = i_in_data.mode;
                    n_p_state = r_state;
                    n_p_count = r_count;
                    n_pct     = '0;
                    n_fsm     = S_DONE;
                    if (!i_in_data.mode) begin
                        // Light sample: darkness test has priority.
                        if (smp_dark) begin
                            if (r_state == ST_LIGHT) begin
                                n_p_count = '0;
                                n_p_state = ST_FADING;
                            end
                        end else if (smp_light) begin
                            if (r_state != ST_LIGHT) begin
                                n_p_count = IDLE_MARK;
                                n_p_state = ST_LIGHT;
                            end
                        end
                    end else begin
                        // Timer tick.
                        n_p_count = cnt_inc;
                        if (r_state == ST_FADING) begin
                            if (fits) begin
                                if (r_fade_ticks == '0) begin
                                    n_pct = DUTY_FULL;
                                end else begin
                                    // 100 * count as 64 + 32 + 4 times count.
                                    n_dvd  = (fc_ext << 6) + (fc_ext << 5) + (fc_ext << 2);
                                    n_rem  = '0;
                                    n_quo  = '0;
                                    n_dcnt = '0;
                                    n_fsm  = S_DIV;
                                end
                            end else begin
                                n_p_count = IDLE_MARK;
                                n_p_state = ST_DARK;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                n_rem  = trial_ge ? TICK_BITS'(trial - {1'b0, r_fade_ticks})
                                  : trial[TICK_BITS-1:0];
                n_dvd  = {r_dvd[DIV_BITS-2:0], 1'b0};
                n_quo  = quo_next;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DIV_CNT_BITS'(DIV_BITS - 1)) begin
                    n_pct = DUTY_FULL - quo_next;
                    n_fsm = S_DONE;
                end
            end
            S_DONE: begin
                if (commit) begin
                    n_state = r_p_state;
                    n_count = r_p_count;
                    if (r_apply) begin
                        n_duty = duty_fin;
                        n_led  = (duty_fin != '0);
                        n_pwm  = (duty_fin != '0) && (duty_fin != DUTY_FULL);
                    end
                    n_out.light_state  = r_p_state;
                    n_out.duty_percent = r_apply ? duty_fin : r_duty;
                    n_out.leds_on      = r_apply ? (duty_fin != '0) : r_led;
                    n_out.pwm_active   = r_apply ? ((duty_fin != '0) && (duty_fin != DUTY_FULL))
                                                 : r_pwm;
                    n_out.elapsed      = ELAPSED_BITS'(r_p_count);
                    n_out_valid        = 1'b1;
                    n_fsm              = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // Control, configuration and committed state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= S_IDLE;
            r_state      <= ST_LIGHT;
            r_count      <= IDLE_MARK;
            r_duty       <= '0;
            r_pwm        <= 1'b0;
            r_led        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dark_thr   <= DARK_THR_RST;
            r_light_thr  <= LIGHT_THR_RST;
            r_fade_ticks <= FADE_TICKS_RST;
            r_min_duty   <= MIN_DUTY_RST;
        end else begin
            r_fsm       <= n_fsm;
            r_state     <= n_state;
            r_count     <= n_count;
            r_duty      <= n_duty;
            r_pwm       <= n_pwm;
            r_led       <= n_led;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_DARK_THR:   r_dark_thr   <= i_cfg_wdata[THR_BITS-1:0];
                    CFG_LIGHT_THR:  r_light_thr  <= i_cfg_wdata[THR_BITS-1:0];
                    CFG_FADE_TICKS: r_fade_ticks <= i_cfg_wdata[TICK_BITS-1:0];
                    CFG_MIN_DUTY:   r_min_duty   <= i_cfg_wdata[DUTY_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: divider, pending request results and output data.
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_apply   <= n_apply;
        r_p_state <= n_p_state;
        r_p_count <= n_p_count;
        r_pct     <= n_pct;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dcnt    <= n_dcnt;
    end

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The divider only runs on a tick during the fade.
    a_div_fading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_DIV) |-> (r_state == ST_FADING))
        else $error("divider running outside the fading state");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_DIV) |-> (r_rem < r_fade_ticks))
        else $error("divider remainder out of range");

    // In the light state the count rests at its idle value.
    a_light_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIGHT) |-> (r_count == IDLE_MARK))
        else $error("count not idle in the light state");

    // PWM only runs with the LEDs enabled.
    a_pwm_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.pwm_active || r_out.leds_on))
        else $error("PWM active with LEDs off");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Dusk fade light controller testbench
// Drives light samples and timer ticks through the request channel and checks
// every status result against a cycle-free model of the light, fade and dark
// states. Runs directed corner cases, then randomized fade sequences under
// several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import dflc_pkg::*;

    // Request kinds carried in the mode field.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_IDLE = '1;

    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 122;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 5000;

    // Tracks the controller state and holds the status results still owed.
    class lamp_status_tracker;
        logic [THR_BITS-1:0]   dark_thr;
        logic [THR_BITS-1:0]   light_thr;
        logic [TICK_BITS-1:0]  fade_len;
        logic [DUTY_BITS-1:0]  duty_floor;
        logic [STATE_BITS-1:0] state;
        logic [COUNT_BITS-1:0] fade_count;
        logic [DUTY_BITS-1:0]  duty;
        logic                  pwm;
        logic                  led;
        t_out_res              expected_status[$];
        int unsigned           mismatches;

        function new();
            dark_thr   = DARK_THR_RST;
            light_thr  = LIGHT_THR_RST;
            fade_len   = FADE_TICKS_RST;
            duty_floor = MIN_DUTY_RST;
            state      = ST_LIGHT;
            fade_count = COUNT_IDLE;
            duty       = '0;
            pwm        = 1'b0;
            led        = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_DARK_THR:   dark_thr   = value[THR_BITS-1:0];
                CFG_LIGHT_THR:  light_thr  = value[THR_BITS-1:0];
                CFG_FADE_TICKS: fade_len   = value[TICK_BITS-1:0];
                CFG_MIN_DUTY:   duty_floor = value[DUTY_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Applies a duty: below the floor it is off; full duty is steady on.
        function void set_drive(int unsigned pct);
            if (pct < duty_floor) pct = 0;
            if (pct == 0) begin
                pwm = 1'b0;
                led = 1'b0;
            end else if (pct == DUTY_FULL) begin
                pwm = 1'b0;
                led = 1'b1;
            end else begin
                pwm = 1'b1;
                led = 1'b1;
            end
            duty = pct[DUTY_BITS-1:0];
        endfunction

        // Advances the state for one accepted request and queues its status.
        function void note_request(t_in_req req);
            t_out_res    want;
            int unsigned ratio;
            if (req.mode == MODE_SAMPLE) begin
                // Darkness is tested first, so crossed thresholds favor it.
                if (req.sample < dark_thr) begin
                    if (state == ST_LIGHT) begin
                        fade_count = '0;
                        state      = ST_FADING;
                    end
                end else if (req.sample > light_thr) begin
                    if (state != ST_LIGHT) begin
                        fade_count = COUNT_IDLE;
                        state      = ST_LIGHT;
                    end
                end
            end else begin
                if (state == ST_FADING) begin
                    if (fade_count <= fade_len) begin
                        // A zero fade length gives a zero quotient.
                        ratio = (fade_len == 0) ? 0 : (100 * fade_count) / fade_len;
                        if (ratio > 100) ratio = 100;
                        set_drive(100 - ratio);
                    end else begin
                        set_drive(0);
                        fade_count = COUNT_IDLE;
                        state      = ST_DARK;
                    end
                end else begin
                    set_drive(0);
                end
                if (fade_count != COUNT_IDLE) fade_count = fade_count + 1'b1;
            end
            want.light_state  = state;
            want.duty_percent = duty;
            want.leds_on      = led;
            want.pwm_active   = pwm;
            want.elapsed      = fade_count;
            expected_status.push_back(want);
        endfunction

        // Compares one accepted result with the oldest status owed.
        function void check_result(t_out_res got);
            t_out_res want;
            if (expected_status.size() == 0) begin
                $error("result %h arrived with no request outstanding", got);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            if (got.light_state !== want.light_state) begin
                $error("light_state: expected %0d, got %0d", want.light_state, got.light_state);
                mismatches++;
            end
            if (got.duty_percent !== want.duty_percent) begin
                $error("duty_percent: expected %0d, got %0d",
                       want.duty_percent, got.duty_percent);
                mismatches++;
            end
            if (got.leds_on !== want.leds_on) begin
                $error("leds_on: expected %0d, got %0d", want.leds_on, got.leds_on);
                mismatches++;
            end
            if (got.pwm_active !== want.pwm_active) begin
                $error("pwm_active: expected %0d, got %0d", want.pwm_active, got.pwm_active);
                mismatches++;
            end
            if (got.elapsed !== want.elapsed) begin
                $error("elapsed: expected %0d, got %0d", want.elapsed, got.elapsed);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_in_req                  in_req    = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_res                 out_res;

    lamp_status_tracker sb;
    int  in_idle_pct   = 0;
    int  out_stall_pct = 0;
    logic hold_pending = 1'b0;
    int  quiet_cycles  = 0;

    dusk_fade_light_controller DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_res)
    );

    always #1 clk = ~clk;

    // Result side: random stalls, with one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    // Handshake monitor and watchdog on cycles with no transfer.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_res);
        if (rst_n && in_valid && in_ready) sb.note_request(in_req);
        if (!rst_n || (out_valid && out_ready) || (in_valid && in_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one request, with random idle cycles ahead of it.
    task automatic send_request(input logic mode, input logic [SAMPLE_BITS-1:0] sample);
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= {mode, sample};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    // Writes all four registers back to back.
    task automatic load_settings(input logic [THR_BITS-1:0] dark, input logic [THR_BITS-1:0] light,
                                 input logic [TICK_BITS-1:0] span,
                                 input logic [DUTY_BITS-1:0] min_pct);
        write_reg(CFG_DARK_THR, CFG_DATA_BITS'(dark));
        write_reg(CFG_LIGHT_THR, CFG_DATA_BITS'(light));
        write_reg(CFG_FADE_TICKS, CFG_DATA_BITS'(span));
        write_reg(CFG_MIN_DUTY, CFG_DATA_BITS'(min_pct));
        cfg_we <= 1'b0;
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One fade sequence: a dark sample, ticks with some noise, a light sample.
    task automatic run_fade_cycle(inout int sent);
        int ticks;
        int span;
        logic [SAMPLE_BITS-1:0] level;
        span  = (sb.fade_len > 44) ? 48 : int'(sb.fade_len) + 4;
        ticks = $urandom_range(span, 1);
        level = SAMPLE_BITS'($urandom);
        if (sb.dark_thr != 0) level = SAMPLE_BITS'($urandom_range(sb.dark_thr - 1, 0));
        send_request(MODE_SAMPLE, level);
        repeat (ticks) begin
            level = SAMPLE_BITS'($urandom);
            if ($urandom_range(99) < 88) begin
                send_request(MODE_TICK, level);
            end else begin
                send_request(MODE_SAMPLE, level);
            end
        end
        level = SAMPLE_BITS'($urandom);
        if (sb.light_thr != '1) level = SAMPLE_BITS'($urandom_range(1023, sb.light_thr + 1));
        send_request(MODE_SAMPLE, level);
        sent += ticks + 2;
    endtask

    // Main sequence: reset, directed corners, randomized segments, verdict.
    initial begin
        int sent;
        int roll;
        logic [THR_BITS-1:0]  dark;
        logic [THR_BITS-1:0]  light;
        logic [TICK_BITS-1:0] span;
        logic [DUTY_BITS-1:0] min_pct;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: threshold edges, fade start, return to light.
        send_request(MODE_TICK, 10'h3FF);
        send_request(MODE_SAMPLE, 10'd143);
        send_request(MODE_TICK, 10'd0);
        send_request(MODE_TICK, 10'd0);
        send_request(MODE_SAMPLE, 10'd0);
        send_request(MODE_SAMPLE, 10'd161);
        send_request(MODE_SAMPLE, 10'd144);
        send_request(MODE_SAMPLE, 10'd160);
        send_request(MODE_SAMPLE, 10'h3FF);
        send_request(MODE_SAMPLE, 10'd0);
        wait_drained();

        // Zero fade length: full duty for one tick, then dark.
        load_settings(DARK_THR_RST, LIGHT_THR_RST, 16'd0, 7'd0);
        send_request(MODE_TICK, 10'd0);
        send_request(MODE_TICK, 10'd0);
        send_request(MODE_TICK, 10'd0);
        send_request(MODE_SAMPLE, 10'd0);
        send_request(MODE_SAMPLE, 10'h3FF);
        wait_drained();

        // Crossed thresholds, maximal fade length and a floor above full duty.
        load_settings(10'h3FF, 10'd0, 16'hFFFF, 7'h7F);
        send_request(MODE_SAMPLE, 10'd512);
        send_request(MODE_TICK, 10'd0);
        send_request(MODE_TICK, 10'd0);
        send_request(MODE_SAMPLE, 10'h3FF);
        wait_drained();

        // Thresholds that no sample can cross.
        load_settings(10'd0, 10'h3FF, 16'd3, 7'd100);
        send_request(MODE_SAMPLE, 10'd0);
        send_request(MODE_SAMPLE, 10'h3FF);
        wait_drained();

        // Short fade through PWM duty, the floor, zero duty and into dark.
        load_settings(10'h3FF, 10'h3FF, 16'd3, 7'd50);
        send_request(MODE_SAMPLE, 10'd0);
        repeat (5) send_request(MODE_TICK, 10'd0);
        wait_drained();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // Mostly ordered thresholds; sometimes anything goes.
            if ($urandom_range(3) != 0) begin
                dark  = THR_BITS'($urandom_range(900, 1));
                light = THR_BITS'($urandom_range(1022, dark));
            end else begin
                dark  = THR_BITS'($urandom_range(1023, 0));
                light = THR_BITS'($urandom_range(1023, 0));
            end
            roll = $urandom_range(9);
            if (roll < 7) begin
                span = TICK_BITS'($urandom_range(40, 1));
            end else if (roll == 7) begin
                span = 16'd0;
            end else if (roll == 8) begin
                span = 16'hFFFF;
            end else begin
                span = TICK_BITS'($urandom_range(65535, 0));
            end
            min_pct = DUTY_BITS'(($urandom_range(4) != 0) ? $urandom_range(100, 0)
                                                          : $urandom_range(127, 0));
            load_settings(dark, light, span, min_pct);

            case (seg % 4)
                0: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct   = 77;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 77;
                end
                default: begin
                    in_idle_pct   = 24;
                    out_stall_pct = 24;
                end
            endcase
            // Back pressure: the result side holds off while requests keep coming.
            if (seg == 0) hold_pending = 1'b1;

            sent = 0;
            while (sent < SEG_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    run_fade_cycle(sent);
                end else begin
                    send_request(1'($urandom), SAMPLE_BITS'($urandom));
                    sent++;
                end
            end
            wait_drained();
        end

        if (sb.expected_status.size() != 0) begin
            $error("%0d results never arrived", sb.expected_status.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
